// ----- src/rgbhr_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbhr_pkg: shared types and constants for the hue rotation block
// pixel channel width and rotation mode codes
// ----------------------------------------------------------------------------
package rgbhr_pkg;

	localparam int ChanW = 8;

	typedef logic [ChanW-1:0] chan_t;
	typedef logic [ChanW:0]   sum_t;

	typedef enum logic {
		FUNC_COMP  = 1'b0,
		FUNC_TRIAD = 1'b1
	} func_t;

	typedef struct packed {
		logic  vld;
		func_t func;
		chan_t red;
		chan_t green;
		chan_t blue;
	} pix_t;

endpackage

// ----- src/rgb_hue_rotate.sv -----
// An accepted start passes through pix_s1, pix_s2 and res_s3 to the done strobe.
// Throughput: one pixel per cycle; busy is held low, so start may stay high.
// Results cannot be stalled: each shows on the output ports for one cycle.
// Reset (arst_n low) clears the valid bits, dropping any requests in flight.
// ----------------------------------------------------------------------------
// rgb_hue_rotate: HSL hue rotation of an 8-bit RGB pixel
// complementary mode reflects each channel about (max+min)/2,
// triadic mode rotates the channels
// ----------------------------------------------------------------------------
module rgb_hue_rotate (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  rgbhr_pkg::chan_t   red,
	input  rgbhr_pkg::chan_t   green,
	input  rgbhr_pkg::chan_t   blue,
	output logic               done,
	output rgbhr_pkg::chan_t   red_out,
	output rgbhr_pkg::chan_t   green_out,
	output rgbhr_pkg::chan_t   blue_out
);
	import rgbhr_pkg::*;

	pix_t pix_in;
	pix_t pix_s2;
	sum_t sum_s2;
	pix_t res_s3;

	assign busy = 1'b0;

	// incoming request
	always_comb begin
		pix_in.vld   = start;
		pix_in.func  = func_t'(func);
		pix_in.red   = red;
		pix_in.green = green;
		pix_in.blue  = blue;
	end

	rgbhr_extent u_extent (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_in),
		.pix_s2 (pix_s2),
		.sum_s2 (sum_s2)
	);

	// stage 3: reflect or rotate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s3 <= '0;
		end else begin
			res_s3.vld  <= pix_s2.vld;
			res_s3.func <= pix_s2.func;
			unique case (pix_s2.func)
				FUNC_COMP: begin
					res_s3.red   <= ChanW'(sum_s2 - {1'b0, pix_s2.red});
					res_s3.green <= ChanW'(sum_s2 - {1'b0, pix_s2.green});
					res_s3.blue  <= ChanW'(sum_s2 - {1'b0, pix_s2.blue});
				end
				FUNC_TRIAD: begin
					res_s3.red   <= pix_s2.blue;
					res_s3.green <= pix_s2.red;
					res_s3.blue  <= pix_s2.green;
				end
				default: begin
					res_s3.red   <= pix_s2.red;
					res_s3.green <= pix_s2.green;
					res_s3.blue  <= pix_s2.blue;
				end
			endcase
		end
	end

	assign done      = res_s3.vld;
	assign red_out   = res_s3.red;
	assign green_out = res_s3.green;
	assign blue_out  = res_s3.blue;

endmodule

// ----- src/rgbhr_extent.sv -----
// ----------------------------------------------------------------------------
// rgbhr_extent: channel extent stage
// finds max and min of the pixel and registers max + min with the pixel
// ----------------------------------------------------------------------------
module rgbhr_extent (
	input  logic            clk,
	input  logic            arst_n,
	input  rgbhr_pkg::pix_t pix,
	output rgbhr_pkg::pix_t pix_s2,
	output rgbhr_pkg::sum_t sum_s2
);
	import rgbhr_pkg::*;

	pix_t  pix_s1;
	chan_t mx_s1;
	chan_t mn_s1;
	chan_t mx_a;
	chan_t mn_a;

	// stage 1: register request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1 <= '0;
		end else begin
			pix_s1 <= pix;
		end
	end
	always_ff @(posedge clk) begin
		mx_s1 <= (pix.red > pix.green) ? pix.red : pix.green;
		mn_s1 <= (pix.red < pix.green) ? pix.red : pix.green;
	end

	// finish max and min against blue
	assign mx_a = (mx_s1 > pix_s1.blue) ? mx_s1 : pix_s1.blue;
	assign mn_a = (mn_s1 < pix_s1.blue) ? mn_s1 : pix_s1.blue;

	// stage 2: register extent sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s2 <= '0;
		end else begin
			pix_s2 <= pix_s1;
		end
	end
	always_ff @(posedge clk) begin
		sum_s2 <= {1'b0, mx_a} + {1'b0, mn_a};
	end

endmodule
